FILE: design/text_console_writer_core_assert.svh
// Assertion macros used by the console checker file.
`ifndef TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define TCW_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define TCW_ASSERT(lbl, prop, msg) \
  `TCW_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: design/tcw_pkg.sv
// Shared widths, codes and cell helpers for the text console writer.
`default_nettype none

package tcw_pkg;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned IDX_W   = 11;
  localparam int unsigned CELL_W  = 16;
  localparam int unsigned COLP_W  = 7;
  localparam int unsigned ROWP_W  = 5;
  localparam int unsigned COLOR_W = 4;

  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'd10;
  localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'd32;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 4'd15;

  // Black background in the top nibble, foreground below, character low.
  function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                  input logic [COLOR_W-1:0] fg);
    make_cell = {4'h0, fg, ch};
  endfunction

endpackage

`default_nettype wire

FILE: design/text_console_writer_core.sv
// Text console writer: screen memory, cursor and scroll/clear sequencer.
//
// Requests arrive on the in channel (valid/ready) with a mode, a character
// and a cell index; each request gives one result on the out channel
// (valid/ready). The cfg channel writes the foreground colour; it is always
// ready and is meant to be used only while no request is in flight.
// A plain put, a read or an unused mode goes through the finish state into
// the output register. A put that runs past the last row scrolls the
// screen: the sequencer copies ROWS*COLUMNS-COLUMNS cells one per cycle
// through the screen RAM (read one row ahead, write back in the next
// cycle), then blanks the last row. A clear blanks every cell, one write
// per cycle. The screen RAM has a single write port; one request is in
// work at a time. After reset a clearing pass writes every cell blank
// white on black; in_ready_o stays low meanwhile.
// When the receiver stalls the result waits in the output register; the
// block still takes the next request and holds its result until the
// output register frees up.
`default_nettype none

module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [COLOR_W-1:0] cfg_text_color_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [MODE_W-1:0]  in_mode_i,
  input  wire logic [CHAR_W-1:0]  in_char_code_i,
  input  wire logic [IDX_W-1:0]   in_cell_index_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [CELL_W-1:0]  out_cell_value_o,
  output logic      [COLP_W-1:0]  out_cursor_column_o,
  output logic      [ROWP_W-1:0]  out_cursor_row_o,
  output logic                    out_scrolled_o
);

  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
  localparam int unsigned COPY_COUNT = CELL_COUNT - COLUMNS;
  localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);
  localparam int unsigned COL_W      = $clog2(COLUMNS);
  localparam int unsigned ROW_W      = $clog2(ROWS);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_BLANK,
    ST_CLEAR,
    ST_FINISH
  } state_e;

  state_e              state_q;
  logic [ADDR_W-1:0]   cnt_q;
  logic [COL_W-1:0]    col_q;
  logic [ROW_W-1:0]    line_q;
  logic [COLOR_W-1:0]  color_q;
  logic                res_rd_q;
  logic                res_scr_q;
  logic                out_valid_q;
  logic [CELL_W-1:0]   out_cell_q;
  logic [COLP_W-1:0]   out_col_q;
  logic [ROWP_W-1:0]   out_row_q;
  logic                out_scr_q;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [CELL_W-1:0]   ram_rdata;

  logic                in_fire;
  logic                is_nl;
  logic                idx_ok;
  logic [COL_W:0]      col_inc;
  logic [ROW_W:0]      line_inc;
  logic                adv_line;
  logic                do_scroll;
  logic [COL_W-1:0]    col_d;
  logic [ROW_W-1:0]    line_d;
  logic [ADDR_W-1:0]   cur_pos;
  logic [CELL_W-1:0]   blank_cell;
  logic                last_cell;
  logic                out_free;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  assign is_nl      = (in_char_code_i == NEWLINE_CHAR);
  assign idx_ok     = (32'(in_cell_index_i) < CELL_COUNT);
  assign col_inc    = {1'b0, col_q} + 1'b1;
  assign line_inc   = {1'b0, line_q} + 1'b1;
  assign adv_line   = is_nl || (col_inc == (COL_W + 1)'(COLUMNS));
  assign do_scroll  = adv_line && (line_inc == (ROW_W + 1)'(ROWS));
  assign col_d      = adv_line ? '0 : col_inc[COL_W-1:0];
  assign cur_pos    = ADDR_W'(line_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
  assign blank_cell = make_cell(BLANK_CHAR, color_q);
  assign last_cell  = (cnt_q == ADDR_W'(CELL_COUNT - 1));

  always_comb begin
    if (do_scroll) begin
      line_d = ROW_W'(ROWS - 1);
    end else if (adv_line) begin
      line_d = line_inc[ROW_W-1:0];
    end else begin
      line_d = line_q;
    end
  end

  // Screen RAM port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = blank_cell;
    ram_re    = 1'b0;
    ram_raddr = ADDR_W'(in_cell_index_i);
    unique case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = make_cell(BLANK_CHAR, RESET_COLOR);
      end
      ST_IDLE: begin
        if (in_fire && in_mode_i == MODE_PUT && !is_nl) begin
          ram_we    = 1'b1;
          ram_waddr = cur_pos;
          ram_wdata = make_cell(in_char_code_i, color_q);
        end
        ram_re = in_fire && (in_mode_i == MODE_READ) && idx_ok;
      end
      ST_SCROLL: begin
        // Read one row below, write back the cell read the cycle before.
        ram_re    = (cnt_q != ADDR_W'(COPY_COUNT));
        ram_raddr = cnt_q + ADDR_W'(COLUMNS);
        ram_we    = (cnt_q != '0);
        ram_waddr = cnt_q - 1'b1;
        ram_wdata = ram_rdata;
      end
      ST_BLANK, ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_FINISH: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELL_COUNT)
  ) u_screen_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      col_q       <= '0;
      line_q      <= '0;
      color_q     <= RESET_COLOR;
      res_rd_q    <= 1'b0;
      res_scr_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_cell_q  <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_scr_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        color_q <= cfg_text_color_i;
      end
      // Load a finished result, else drop the one just taken.
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_INIT: begin
          if (last_cell) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            unique case (in_mode_i)
              MODE_PUT: begin
                col_q     <= col_d;
                line_q    <= line_d;
                res_rd_q  <= 1'b0;
                res_scr_q <= do_scroll;
                if (do_scroll) begin
                  cnt_q   <= '0;
                  state_q <= ST_SCROLL;
                end else begin
                  state_q <= ST_FINISH;
                end
              end
              MODE_READ: begin
                res_rd_q  <= idx_ok;
                res_scr_q <= 1'b0;
                state_q   <= ST_FINISH;
              end
              MODE_CLEAR: begin
                col_q     <= '0;
                line_q    <= '0;
                cnt_q     <= '0;
                res_rd_q  <= 1'b0;
                res_scr_q <= 1'b0;
                state_q   <= ST_CLEAR;
              end
              default: begin
                res_rd_q  <= 1'b0;
                res_scr_q <= 1'b0;
                state_q   <= ST_FINISH;
              end
            endcase
          end
        end
        ST_SCROLL: begin
          // Counter stops on the first cell of the last row.
          if (cnt_q == ADDR_W'(COPY_COUNT)) begin
            state_q <= ST_BLANK;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_BLANK, ST_CLEAR: begin
          if (last_cell) begin
            cnt_q   <= '0;
            state_q <= ST_FINISH;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_cell_q <= res_rd_q ? ram_rdata : '0;
            out_col_q  <= COLP_W'(col_q);
            out_row_q  <= ROWP_W'(line_q);
            out_scr_q  <= res_scr_q;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_cell_value_o    = out_cell_q;
  assign out_cursor_column_o = out_col_q;
  assign out_cursor_row_o    = out_row_q;
  assign out_scrolled_o      = out_scr_q;

endmodule

`default_nettype wire

FILE: design/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: design/tcw_checker.sv
// Port-level checker for the text console writer, bound to the top level.
`default_nettype none

`include "text_console_writer_core_assert.svh"

module tcw_checker
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [CELL_W-1:0]  out_cell_value_o,
  input wire logic [COLP_W-1:0]  out_cursor_column_o,
  input wire logic [ROWP_W-1:0]  out_cursor_row_o,
  input wire logic               out_scrolled_o
);

  // Hold a stalled result.
  property p_out_hold;
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_cell_value_o) &&
      $stable(out_cursor_column_o) && $stable(out_cursor_row_o);
  endproperty

  // A scroll leaves the cursor at the start of the last row.
  property p_scroll_home;
    out_valid_o && out_scrolled_o |->
      out_cursor_column_o == '0 && 32'(out_cursor_row_o) == ROWS - 1;
  endproperty

  property p_cursor_range;
    out_valid_o |-> 32'(out_cursor_column_o) < COLUMNS && 32'(out_cursor_row_o) < ROWS;
  endproperty

  // Every stored cell has a black background.
  property p_black_bg;
    out_valid_o |-> out_cell_value_o[15:12] == 4'h0;
  endproperty

  // One request in work at a time.
  property p_one_request;
    in_valid_i && in_ready_o |=> !in_ready_o;
  endproperty

  `TCW_ASSERT(a_out_hold, p_out_hold, "stalled result changed")
  `TCW_ASSERT(a_scroll_home, p_scroll_home, "scroll cursor not on last row")
  `TCW_ASSERT(a_cursor_range, p_cursor_range, "cursor out of screen")
  `TCW_ASSERT(a_black_bg, p_black_bg, "cell background not black")
  `TCW_ASSERT(a_one_request, p_one_request, "request taken while one is in work")

endmodule

bind text_console_writer_core tcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcw_checker (.*);

`default_nettype wire
